@@ hw/rtl/peak_hold_decay_meter_defines.svh @@
// assertion macros for the peak hold decay meter
// used by the top level; no other dependencies
`ifndef PEAK_HOLD_DECAY_METER_DEFINES_SVH
`define PEAK_HOLD_DECAY_METER_DEFINES_SVH

`ifndef SYNTH

// clocked assertion, off while reset is active
`define PHDM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define PHDM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PHDM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PHDM_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/phdm_pkg.sv @@
// shared types, codes and widths for the peak hold decay meter
// no dependencies
`default_nettype none

package phdm_pkg;

	// field and register widths
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int AGE_W           = 32;
	localparam int HOLD_W          = 24;
	localparam int INTERVAL_W      = 24;
	localparam int FACTOR_W        = 16;
	localparam int BLEN_W          = 16;
	localparam int KIND_W          = 2;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 24;
	localparam int DIV_CNT_W       = $clog2(AGE_W);

	// register reset values
	localparam logic [HOLD_W-1:0]     HOLD_RST     = 24'd0;
	localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 24'd4800;
	localparam logic [FACTOR_W-1:0]   FACTOR_RST   = 16'd58982;

	// input item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 2'd0,
		KIND_EOB    = 2'd1,
		KIND_CLEAR  = 2'd2
	} kind_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HOLD     = 2'd0,
		CFG_INTERVAL = 2'd1,
		CFG_FACTOR   = 2'd2
	} cfg_idx_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_AGE,
		ST_DIV,
		ST_FIN
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take_sample;
		logic take_clear;
		logic take_eob;
		logic start_decay;
		logic div_step;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic decay_needed;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/peak_hold_decay_meter.sv @@
// peak hold decay meter: sample and clear items are accepted back to back while idle.
// an end-of-block item holds the input through the age check, the 32-step
// restoring remainder unit when a decay step runs, and the finish state, which
// waits for a free output slot; its result is held in an output register.
// async active-low reset clears peak, block max and age and loads config defaults.
`default_nettype none

`include "peak_hold_decay_meter_defines.svh"

module peak_hold_decay_meter
	import phdm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [KIND_W-1:0]             kind,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [BLEN_W-1:0]             block_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [SAMPLE_BITS-1:0]        peak_level,
	output logic [AGE_W-1:0]              samples_since_peak
);

	cmd_t  cmd;
	stat_t stat;

	// controller
	phdm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath
	phdm_datapath #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.sample             (sample),
		.block_length       (block_length),
		.cmd                (cmd),
		.stat               (stat),
		.out_ready          (out_ready),
		.out_valid          (out_valid),
		.peak_level         (peak_level),
		.samples_since_peak (samples_since_peak)
	);

	// sequencer commands never overlap
	`PHDM_ASSERT_ALWAYS(a_cmd_onehot, clk, $onehot0({cmd.take_eob, cmd.start_decay, cmd.div_step, cmd.finish}), "overlapping sequencer commands")
	// no remainder step while input is open
	`PHDM_ASSERT(a_no_step_ready, clk, arst_n, in_ready |-> !cmd.div_step, "remainder step while ready")
	// remainder unit runs right after the decay load
	`PHDM_ASSERT(a_div_follows, clk, arst_n, cmd.start_decay |=> cmd.div_step, "remainder unit did not start")
	// result written only into a free output slot
	`PHDM_ASSERT(a_finish_free, clk, arst_n, cmd.finish |-> stat.out_free, "result overwrote pending transfer")

endmodule

`default_nettype wire

@@ hw/rtl/phdm_ctrl.sv @@
// controller state machine for the peak hold decay meter
// depends on phdm_pkg
`default_nettype none

module phdm_ctrl
	import phdm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [KIND_W-1:0] kind,
	output logic              in_ready,
	input  stat_t             stat,
	output cmd_t              cmd
);

	state_t state_q;
	state_t state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (kind_t'(kind))
						KIND_SAMPLE: cmd.take_sample = 1'b1;
						KIND_CLEAR:  cmd.take_clear  = 1'b1;
						KIND_EOB: begin
							cmd.take_eob = 1'b1;
							state_nxt    = ST_AGE;
						end
						default: ;
					endcase
				end
			end
			ST_AGE: begin
				if (stat.decay_needed) begin
					cmd.start_decay = 1'b1;
					state_nxt       = ST_DIV;
				end else begin
					state_nxt = ST_FIN;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_nxt = ST_FIN;
				end
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/phdm_datapath.sv @@
// datapath of the peak hold decay meter: config, peak state, decay multiply,
// restoring remainder unit and output register; depends on phdm_pkg
`default_nettype none

module phdm_datapath
	import phdm_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [BLEN_W-1:0]             block_length,
	input  cmd_t                          cmd,
	output stat_t                         stat,
	input  logic                          out_ready,
	output logic                          out_valid,
	output logic [SAMPLE_BITS-1:0]        peak_level,
	output logic [AGE_W-1:0]              samples_since_peak
);

	localparam int PROD_W = SAMPLE_BITS + FACTOR_W;

	logic [HOLD_W-1:0]      hold_q;
	logic [INTERVAL_W-1:0]  interval_q;
	logic [FACTOR_W-1:0]    factor_q;
	logic [SAMPLE_BITS-1:0] peak_q;
	logic [SAMPLE_BITS-1:0] bmax_q;
	logic [AGE_W-1:0]       age_q;
	logic [AGE_W-1:0]       work_age_q;
	logic [INTERVAL_W-1:0]  rem_q;
	logic [AGE_W-1:0]       dvd_q;
	logic [DIV_CNT_W-1:0]   cnt_q;
	logic                   out_valid_q;
	logic [SAMPLE_BITS-1:0] out_peak_q;
	logic [AGE_W-1:0]       out_age_q;

	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic [AGE_W:0]         age_sum;
	logic [AGE_W-1:0]       age_sat;
	logic [INTERVAL_W-1:0]  interval_eff;
	logic [AGE_W-1:0]       hold_ext;
	logic [AGE_W-1:0]       after;
	logic [PROD_W-1:0]      prod;
	logic [INTERVAL_W:0]    rem_sh;
	logic [INTERVAL_W:0]    rem_sub;
	logic [INTERVAL_W-1:0]  rem_nxt;
	logic                   new_peak;

	// sample magnitude, most negative value maps to 2^(n-1)
	assign raw = sample;
	assign mag = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;

	// saturating age after adding the block length
	assign age_sum = {1'b0, age_q} + (AGE_W + 1)'(block_length);
	assign age_sat = age_sum[AGE_W] ? {AGE_W{1'b1}} : age_sum[AGE_W-1:0];

	// decay decision, zero interval acts as one
	assign interval_eff      = (interval_q == '0) ? INTERVAL_W'(1) : interval_q;
	assign hold_ext          = AGE_W'(hold_q);
	assign after             = work_age_q - hold_ext;
	assign stat.decay_needed = (work_age_q > hold_ext) && (after >= AGE_W'(interval_eff));

	// decay multiply, q0.16 factor, truncated
	assign prod = PROD_W'(peak_q) * PROD_W'(factor_q);

	// one restoring step of the remainder unit
	assign rem_sh  = {rem_q, dvd_q[AGE_W-1]};
	assign rem_sub = rem_sh - {1'b0, interval_eff};
	assign rem_nxt = (rem_sh >= {1'b0, interval_eff}) ? rem_sub[INTERVAL_W-1:0]
	                                                  : rem_sh[INTERVAL_W-1:0];
	assign stat.div_last = (cnt_q == '0);

	assign new_peak      = bmax_q > peak_q;
	assign stat.out_free = !out_valid_q || out_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q     <= HOLD_RST;
			interval_q <= INTERVAL_RST;
			factor_q   <= FACTOR_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HOLD:     hold_q     <= cfg_data[HOLD_W-1:0];
				CFG_INTERVAL: interval_q <= cfg_data[INTERVAL_W-1:0];
				CFG_FACTOR:   factor_q   <= cfg_data[FACTOR_W-1:0];
				default: ;
			endcase
		end
	end

	// held peak, block maximum and age
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			bmax_q <= '0;
			age_q  <= '0;
		end else begin
			if (cmd.take_sample && (mag > bmax_q)) begin
				bmax_q <= mag;
			end
			if (cmd.take_clear) begin
				peak_q <= '0;
				age_q  <= '0;
			end
			if (cmd.start_decay) begin
				peak_q <= prod[PROD_W-1:FACTOR_W];
			end
			if (cmd.finish) begin
				bmax_q <= '0;
				if (new_peak) begin
					peak_q <= bmax_q;
					age_q  <= '0;
				end else begin
					age_q <= work_age_q;
				end
			end
		end
	end

	// working age and remainder unit
	always_ff @(posedge clk) begin
		if (cmd.take_eob) begin
			work_age_q <= age_sat;
		end
		if (cmd.start_decay) begin
			rem_q <= '0;
			dvd_q <= after;
			cnt_q <= DIV_CNT_W'(AGE_W - 1);
		end
		if (cmd.div_step) begin
			rem_q <= rem_nxt;
			dvd_q <= {dvd_q[AGE_W-2:0], 1'b0};
			cnt_q <= cnt_q - DIV_CNT_W'(1);
			if (stat.div_last) begin
				work_age_q <= hold_ext + AGE_W'(rem_nxt);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_peak_q <= new_peak ? bmax_q : peak_q;
			out_age_q  <= new_peak ? '0 : work_age_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign peak_level         = out_peak_q;
	assign samples_since_peak = out_age_q;

endmodule

`default_nettype wire
